/* rtl/core/btl_pkg.sv */
// Shared types and constants of the BMP texture loader and nearest-texel sampler.
package btl_pkg;

   localparam int MAX_DIM   = 256;
   localparam int FRAC_BITS = 16;

   // A dimension must hold MAX_DIM itself; a position only MAX_DIM - 1.
   localparam int DIM_BITS  = $clog2(MAX_DIM + 1);
   localparam int POS_BITS  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int ADDR_BITS = 2 * POS_BITS;
   localparam int TEXELS    = MAX_DIM * MAX_DIM;
   localparam int SUM_BITS  = FRAC_BITS + POS_BITS;
   localparam int TEXEL_BITS = 24;
   localparam int COORD_BITS = 24;

   localparam logic [7:0]  SIG_FIRST  = 8'h42;
   localparam logic [7:0]  SIG_SECOND = 8'h4d;
   localparam logic [15:0] BIT_DEPTH  = 16'd24;
   localparam logic [31:0] MIN_OFFSET = 32'd30;

   localparam logic [31:0] IDX_SIG_FIRST  = 32'd0;
   localparam logic [31:0] IDX_SIG_SECOND = 32'd1;
   localparam logic [31:0] IDX_OFFSET_END = 32'd13;
   localparam logic [31:0] IDX_WIDTH_END  = 32'd21;
   localparam logic [31:0] IDX_HEIGHT_END = 32'd25;
   localparam logic [31:0] IDX_DEPTH_END  = 32'd29;

   localparam logic [7:0] MAGENTA_RED   = 8'hff;
   localparam logic [7:0] MAGENTA_GREEN = 8'h00;
   localparam logic [7:0] MAGENTA_BLUE  = 8'hff;

   localparam logic OP_BYTE     = 1'b0;
   localparam logic OP_SAMPLE   = 1'b1;
   localparam logic KIND_COLOR  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_SIG    = 3'd1,
      ST_BAD_DEPTH  = 3'd2,
      ST_BAD_SIZE   = 3'd3,
      ST_BAD_OFFSET = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HEADER,
      PH_SKIP,
      PH_PIXEL,
      PH_PAD
   } phase_type;

   typedef enum logic [2:0] {
      CTL_ACCEPT,
      CTL_MUL,
      CTL_ADDR,
      CTL_READ,
      CTL_DATA
   } ctl_type;

endpackage

/* rtl/core/btl_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module btl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/bmp_texture_load_and_nearest_sample.sv */
// Top level of the 24-bit BMP texture loader and nearest-texel sampler.
//
// Items arrive on the req_ channel: a file byte (tuser bit 0 low) or a sample
// request (tuser bit 0 high); tuser bit 1 marks the first byte of a new file
// and restarts the parser. Each file byte is handled as it is transferred: the
// header is parsed as it streams past, pixel bytes are assembled into texels
// and written to a 64K x 24 texel RAM, and one status transfer reports a
// completed load or the first header fault. A sample request passes through
// fraction capture, the fraction-times-size multiply, the row-times-width
// address multiply, the RAM read and the output register. Magenta is returned
// while no texture is loaded. The texel RAM is not cleared after reset, so no
// clearing pass runs. A result waits in an output register, and the next item
// is taken in the cycle that the result is transferred.
module bmp_texture_load_and_nearest_sample
   import btl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // stream_byte[7:0], u_coord[31:8], v_coord[55:32]
   input  logic [55:0] req_tdata,
   // operation[0], start_of_file[1]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // red[7:0], green[15:8], blue[23:16], load_status[26:24], zero[31:27]
   output logic [31:0] rsp_tdata,
   // result_kind[0]
   output logic        rsp_tuser
);

   logic [7:0]              in_byte;
   logic signed [COORD_BITS-1:0] in_u;
   logic signed [COORD_BITS-1:0] in_v;
   logic                    in_op;
   logic                    in_sof;
   logic                    req_fire;
   logic                    byte_fire;
   logic                    sample_fire;

   phase_type               phase_ff, phase_in;
   logic [31:0]             cnt_ff, cnt_in;
   logic [31:0]             field_ff, field_in;
   logic [31:0]             offset_ff, offset_in;
   logic [DIM_BITS-1:0]     width_ff, width_in;
   logic [DIM_BITS-1:0]     height_ff, height_in;
   logic [POS_BITS-1:0]     col_ff, col_in;
   logic [POS_BITS-1:0]     row_ff, row_in;
   logic [1:0]              chan_ff, chan_in;
   logic [1:0]              pad_ff, pad_in;
   logic [15:0]             held_ff, held_in;
   logic                    tex_valid_ff, tex_valid_in;
   logic                    size_bad_ff, size_bad_in;
   logic [ADDR_BITS-1:0]    row_base_ff, row_base_in;

   logic                    status_fire;
   status_type              status_code;
   logic                    size_bad_now;
   logic [DIM_BITS+POS_BITS-1:0] base_prod;

   logic                    mem_we;
   logic [ADDR_BITS-1:0]    mem_waddr;
   logic [TEXEL_BITS-1:0]   mem_wdata;
   logic                    mem_re;
   logic [TEXEL_BITS-1:0]   mem_rdata;

   ctl_type                 ctl_ff, ctl_in;
   logic                    sample_done;
   logic [FRAC_BITS-1:0]    frac_u_ff, frac_v_ff;
   logic [SUM_BITS-1:0]     sum_x_ff, sum_y_ff;
   logic [ADDR_BITS-1:0]    rd_addr_ff;
   logic [POS_BITS-1:0]     dim_x_max, dim_y_max;
   logic [POS_BITS-1:0]     pos_x, pos_y, pick_x, pick_y;
   logic [DIM_BITS+POS_BITS-1:0] addr_prod;

   logic                    rsp_valid_ff;
   logic                    rsp_kind_ff;
   logic [7:0]              rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   status_type              rsp_status_ff;

   assign in_byte = req_tdata[7:0];
   assign in_u    = req_tdata[31:8];
   assign in_v    = req_tdata[55:32];
   assign in_op   = req_tuser[0];
   assign in_sof  = req_tuser[1];

   assign req_tready  = (ctl_ff == CTL_ACCEPT) && (!rsp_valid_ff || rsp_tready);
   assign req_fire    = req_tvalid && req_tready;
   assign byte_fire   = req_fire && (in_op == OP_BYTE);
   assign sample_fire = req_fire && (in_op == OP_SAMPLE);

   // Header index of the byte in hand: zero when the start marker restarts.
   function automatic logic [31:0] cnt_ff_sel(input logic sof, input logic [31:0] cnt);
      return sof ? 32'd0 : cnt;
   endfunction

   // Parser: every file byte is handled in the cycle of its transfer. A start
   // marker first restores the fresh-file values, and the byte is then parsed
   // from those.
   always_comb begin
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      field_in     = field_ff;
      offset_in    = offset_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      chan_in      = chan_ff;
      pad_in       = pad_ff;
      held_in      = held_ff;
      tex_valid_in = tex_valid_ff;
      size_bad_in  = size_bad_ff;
      row_base_in  = row_base_ff;
      status_fire  = 1'b0;
      status_code  = ST_OK;
      size_bad_now = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = row_base_ff + ADDR_BITS'(col_ff);
      mem_wdata    = {in_byte, held_ff[7:0], held_ff[15:8]};
      base_prod    = '0;

      if (byte_fire) begin
         if (in_sof) begin
            phase_in     = PH_HEADER;
            cnt_in       = '0;
            field_in     = '0;
            offset_in    = '0;
            width_in     = '0;
            height_in    = '0;
            col_in       = '0;
            row_in       = '0;
            chan_in      = '0;
            pad_in       = '0;
            held_in      = '0;
            tex_valid_in = 1'b0;
            size_bad_in  = 1'b0;
         end

         case (phase_in)
            PH_HEADER: begin
               field_in = {in_byte, field_in[31:8]};
               cnt_in   = cnt_in + 32'd1;
               if ((cnt_ff_sel(in_sof, cnt_ff) == IDX_SIG_FIRST && in_byte != SIG_FIRST) ||
                   (cnt_ff_sel(in_sof, cnt_ff) == IDX_SIG_SECOND && in_byte != SIG_SECOND)) begin
                  status_fire = 1'b1;
                  status_code = ST_BAD_SIG;
                  phase_in    = PH_IDLE;
               end else begin
                  if (cnt_ff_sel(in_sof, cnt_ff) == IDX_OFFSET_END) begin
                     offset_in = field_in;
                  end
                  if (cnt_ff_sel(in_sof, cnt_ff) == IDX_WIDTH_END ||
                      cnt_ff_sel(in_sof, cnt_ff) == IDX_HEIGHT_END) begin
                     size_bad_now = (field_in == 32'd0) || (field_in > 32'(MAX_DIM));
                     if (size_bad_now) begin
                        size_bad_in = 1'b1;
                     end
                     if (cnt_ff_sel(in_sof, cnt_ff) == IDX_WIDTH_END) begin
                        width_in = size_bad_now ? '0 : field_in[DIM_BITS-1:0];
                     end else begin
                        height_in = size_bad_now ? '0 : field_in[DIM_BITS-1:0];
                     end
                  end
                  if (cnt_ff_sel(in_sof, cnt_ff) == IDX_DEPTH_END) begin
                     base_prod = POS_BITS'(height_in - DIM_BITS'(1)) * width_in;
                     if (field_in[31:16] != BIT_DEPTH) begin
                        status_fire = 1'b1;
                        status_code = ST_BAD_DEPTH;
                        phase_in    = PH_IDLE;
                     end else if (size_bad_in) begin
                        status_fire = 1'b1;
                        status_code = ST_BAD_SIZE;
                        phase_in    = PH_IDLE;
                     end else if (offset_in < MIN_OFFSET) begin
                        status_fire = 1'b1;
                        status_code = ST_BAD_OFFSET;
                        phase_in    = PH_IDLE;
                     end else begin
                        row_in      = POS_BITS'(height_in - DIM_BITS'(1));
                        col_in      = '0;
                        chan_in     = '0;
                        row_base_in = base_prod[ADDR_BITS-1:0];
                        phase_in    = (offset_in == MIN_OFFSET) ? PH_PIXEL : PH_SKIP;
                     end
                  end
               end
            end
            PH_SKIP: begin
               cnt_in = cnt_in + 32'd1;
               if (cnt_in == offset_in) begin
                  phase_in = PH_PIXEL;
               end
            end
            PH_PIXEL: begin
               if (chan_in < 2'd2) begin
                  held_in = {held_in[7:0], in_byte};
                  chan_in = chan_in + 2'd1;
               end else begin
                  chan_in   = '0;
                  mem_we    = 1'b1;
                  mem_waddr = row_base_in + ADDR_BITS'(col_in);
                  mem_wdata = {in_byte, held_in[7:0], held_in[15:8]};
                  if (DIM_BITS'(col_in) + DIM_BITS'(1) < width_in) begin
                     col_in = col_in + POS_BITS'(1);
                  end else if (row_in == '0) begin
                     tex_valid_in = 1'b1;
                     status_fire  = 1'b1;
                     status_code  = ST_OK;
                     phase_in     = PH_IDLE;
                  end else if (width_in[1:0] != 2'd0) begin
                     pad_in   = width_in[1:0];
                     phase_in = PH_PAD;
                  end else begin
                     row_in      = row_in - POS_BITS'(1);
                     col_in      = '0;
                     row_base_in = row_base_in - ADDR_BITS'(width_in);
                     phase_in    = PH_PIXEL;
                  end
               end
            end
            PH_PAD: begin
               if (pad_in != 2'd0) begin
                  pad_in = pad_in - 2'd1;
               end
               if (pad_in == 2'd0) begin
                  row_in      = row_in - POS_BITS'(1);
                  col_in      = '0;
                  row_base_in = row_base_in - ADDR_BITS'(width_in);
                  phase_in    = PH_PIXEL;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         cnt_ff       <= '0;
         field_ff     <= '0;
         offset_ff    <= '0;
         width_ff     <= '0;
         height_ff    <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         chan_ff      <= '0;
         pad_ff       <= '0;
         held_ff      <= '0;
         tex_valid_ff <= 1'b0;
         size_bad_ff  <= 1'b0;
         row_base_ff  <= '0;
      end else begin
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         field_ff     <= field_in;
         offset_ff    <= offset_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         chan_ff      <= chan_in;
         pad_ff       <= pad_in;
         held_ff      <= held_in;
         tex_valid_ff <= tex_valid_in;
         size_bad_ff  <= size_bad_in;
         row_base_ff  <= row_base_in;
      end
   end

   // Sample sequencer.
   always_comb begin
      ctl_in      = ctl_ff;
      mem_re      = 1'b0;
      sample_done = 1'b0;
      case (ctl_ff)
         CTL_ACCEPT: begin
            if (sample_fire) begin
               ctl_in = CTL_MUL;
            end
         end
         CTL_MUL: begin
            ctl_in = CTL_ADDR;
         end
         CTL_ADDR: begin
            ctl_in = CTL_READ;
         end
         CTL_READ: begin
            mem_re = tex_valid_ff;
            ctl_in = CTL_DATA;
         end
         CTL_DATA: begin
            sample_done = 1'b1;
            ctl_in      = CTL_ACCEPT;
         end
         default: begin
            ctl_in = CTL_ACCEPT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= CTL_ACCEPT;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   // The largest index along each axis; a loaded texture has both sizes at
   // least one, so the subtraction never wraps while it matters.
   assign dim_x_max = POS_BITS'(width_ff - DIM_BITS'(1));
   assign dim_y_max = POS_BITS'(height_ff - DIM_BITS'(1));
   assign pos_x     = sum_x_ff[SUM_BITS-1:FRAC_BITS];
   assign pos_y     = sum_y_ff[SUM_BITS-1:FRAC_BITS];
   assign pick_x    = (pos_x > dim_x_max) ? dim_x_max : pos_x;
   assign pick_y    = (pos_y > dim_y_max) ? dim_y_max : pos_y;
   assign addr_prod = pick_y * width_ff;

   // The fraction of a two's complement coordinate is its low bits, which is
   // already the wrap to the unit interval.
   always_ff @(posedge clock) begin
      if (sample_fire) begin
         frac_u_ff <= in_u[FRAC_BITS-1:0];
         frac_v_ff <= in_v[FRAC_BITS-1:0];
      end
      if (ctl_ff == CTL_MUL) begin
         sum_x_ff <= frac_u_ff * dim_x_max + SUM_BITS'(1 << (FRAC_BITS - 1));
         sum_y_ff <= frac_v_ff * dim_y_max + SUM_BITS'(1 << (FRAC_BITS - 1));
      end
      if (ctl_ff == CTL_ADDR) begin
         rd_addr_ff <= addr_prod[ADDR_BITS-1:0] + ADDR_BITS'(pick_x);
      end
   end

   btl_ram #(
      .WIDTH (TEXEL_BITS),
      .DEPTH (TEXELS)
   ) u_texel_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (rd_addr_ff),
      .rd_data (mem_rdata)
   );

   // Output register. A new result is only produced when the register is
   // empty or being emptied in the same cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (status_fire || sample_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (status_fire) begin
         rsp_kind_ff   <= KIND_STATUS;
         rsp_red_ff    <= '0;
         rsp_green_ff  <= '0;
         rsp_blue_ff   <= '0;
         rsp_status_ff <= status_code;
      end else if (sample_done) begin
         rsp_kind_ff   <= KIND_COLOR;
         rsp_status_ff <= ST_OK;
         if (tex_valid_ff) begin
            rsp_red_ff   <= mem_rdata[7:0];
            rsp_green_ff <= mem_rdata[15:8];
            rsp_blue_ff  <= mem_rdata[23:16];
         end else begin
            rsp_red_ff   <= MAGENTA_RED;
            rsp_green_ff <= MAGENTA_GREEN;
            rsp_blue_ff  <= MAGENTA_BLUE;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {5'd0, rsp_status_ff, rsp_blue_ff, rsp_green_ff, rsp_red_ff};

`ifndef ASSERT_OFF
   a_write_in_pixel: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (phase_ff == PH_PIXEL) && (ctl_ff == CTL_ACCEPT))
      else $error("texel write outside pixel phase");

   a_read_when_valid: assert property (@(posedge clock) disable iff (reset)
      mem_re |-> tex_valid_ff && !mem_we)
      else $error("texel read without a loaded texture");

   a_load_done_status: assert property (@(posedge clock) disable iff (reset)
      $rose(tex_valid_ff) |-> rsp_valid_ff && (rsp_kind_ff == KIND_STATUS) &&
                              (rsp_status_ff == ST_OK))
      else $error("texture became valid without an ok status");

   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff == CTL_DATA) |-> !rsp_valid_ff)
      else $error("sample finished while the output register is occupied");

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff != CTL_ACCEPT) |-> !req_tready)
      else $error("input taken while a sample is in progress");
`endif

endmodule

/* sim/tb_bmp_texture_load_and_nearest_sample.sv */
// Self-checking testbench for the BMP texture loader and nearest-texel sampler.
module tb_bmp_texture_load_and_nearest_sample;
   timeunit 1ns;
   timeprecision 1ps;

   import btl_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int TAIL_CYCLES  = 20;
   localparam int RANDOM_ITEMS = 200;

   typedef struct packed {
      logic       kind;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      status_type status;
   } tex_result_t;

   typedef struct packed {
      logic                  op;
      logic                  sof;
      logic [7:0]            data;
      logic [COORD_BITS-1:0] u;
      logic [COORD_BITS-1:0] v;
      logic                  typed;
      logic                  yields;
      tex_result_t           want;
   } script_row_t;

   localparam tex_result_t MAGENTA   = '{KIND_COLOR, MAGENTA_RED, MAGENTA_GREEN, MAGENTA_BLUE,
                                         ST_OK};
   localparam tex_result_t SIG_FAULT = '{KIND_STATUS, 8'h00, 8'h00, 8'h00, ST_BAD_SIG};
   localparam tex_result_t NOTHING   = '0;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // stream_byte[7:0], u_coord[31:8], v_coord[55:32]
   logic [55:0] req_tdata  = '0;
   // operation[0], start_of_file[1]
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // red[7:0], green[15:8], blue[23:16], load_status[26:24], zero[31:27]
   logic [31:0] rsp_tdata;
   // result_kind[0]
   logic        rsp_tuser;

   int          snd_idle_pct = 16;
   int          rcv_idle_pct = 59;
   int          errors       = 0;
   int          cycle_count  = 0;
   int unsigned live_items   = 0;

   tex_result_t due_outputs [$];
   logic [7:0]  file_bytes [$];

   // Predicted state of the loader and sampler.
   phase_type             pr_phase    = PH_IDLE;
   logic [31:0]           hdr_count   = '0;
   logic [31:0]           field_acc   = '0;
   logic [31:0]           data_offset = '0;
   logic [DIM_BITS-1:0]   img_width   = '0;
   logic [DIM_BITS-1:0]   img_height  = '0;
   logic [POS_BITS-1:0]   col         = '0;
   logic [POS_BITS-1:0]   row         = '0;
   logic [1:0]            chan        = '0;
   logic [1:0]            pad_cnt     = '0;
   logic [15:0]           held_bg     = '0;
   logic                  loaded      = 1'b0;
   logic                  size_fault  = 1'b0;
   logic [TEXEL_BITS-1:0] texel_store [TEXELS];

   script_row_t script [14] = '{
      // Nothing is loaded yet, so every sample comes back magenta.
      '{OP_SAMPLE, 1'b0, 8'h00, 24'h000000, 24'h000000, 1'b1, 1'b1, MAGENTA},
      '{OP_SAMPLE, 1'b0, 8'hff, 24'h7fffff, 24'h800000, 1'b1, 1'b1, MAGENTA},
      '{OP_SAMPLE, 1'b1, 8'h42, 24'hffffff, 24'h00ffff, 1'b1, 1'b1, MAGENTA},
      // Stray bytes while idle are dropped.
      '{OP_BYTE, 1'b0, 8'hff, 24'hffffff, 24'hffffff, 1'b1, 1'b0, NOTHING},
      '{OP_BYTE, 1'b0, 8'h00, 24'h000000, 24'h000000, 1'b1, 1'b0, NOTHING},
      '{OP_BYTE, 1'b1, 8'h00, 24'h123456, 24'h654321, 1'b1, 1'b1, SIG_FAULT},
      '{OP_BYTE, 1'b1, SIG_FIRST, 24'h000001, 24'h800001, 1'b1, 1'b0, NOTHING},
      '{OP_BYTE, 1'b0, 8'h51, 24'hfffffe, 24'h7ffffe, 1'b1, 1'b1, SIG_FAULT},
      '{OP_BYTE, 1'b0, SIG_SECOND, 24'h0f0f0f, 24'hf0f0f0, 1'b1, 1'b0, NOTHING},
      '{OP_BYTE, 1'b1, SIG_FIRST, 24'haaaaaa, 24'h555555, 1'b0, 1'b0, NOTHING},
      '{OP_BYTE, 1'b0, SIG_SECOND, 24'h555555, 24'haaaaaa, 1'b0, 1'b0, NOTHING},
      // A sample in the middle of a header still sees no valid texture.
      '{OP_SAMPLE, 1'b0, 8'h5a, 24'h008000, 24'hff7fff, 1'b1, 1'b1, MAGENTA},
      // Restarting mid-header with the wrong first byte.
      '{OP_BYTE, 1'b1, 8'hc2, 24'h000000, 24'hffffff, 1'b1, 1'b1, SIG_FAULT},
      '{OP_BYTE, 1'b1, SIG_SECOND, 24'hffffff, 24'h000000, 1'b1, 1'b1, SIG_FAULT}
   };

   bmp_texture_load_and_nearest_sample DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   function automatic int unsigned nearest_pos(input logic [COORD_BITS-1:0] c,
                                               input int unsigned dim);
      longint unsigned frac;
      longint unsigned pos;
      frac = c[FRAC_BITS-1:0];
      pos = (frac * (dim - 1) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (pos > dim - 1) pos = dim - 1;
      return 32'(pos);
   endfunction

   function automatic tex_result_t status_out(input status_type code);
      tex_result_t r;
      r = '0;
      r.kind = KIND_STATUS;
      r.status = code;
      pr_phase = PH_IDLE;
      return r;
   endfunction

   // Advances the predicted state by one item; returns 1 when a result is due.
   function automatic bit bmp_step(input logic op, input logic sof, input logic [7:0] data,
                                   input logic [COORD_BITS-1:0] u,
                                   input logic [COORD_BITS-1:0] v,
                                   output tex_result_t res);
      logic [31:0]           idx;
      logic                  bad;
      int unsigned           x;
      int unsigned           y;
      int unsigned           addr;
      logic [TEXEL_BITS-1:0] t;
      res = '0;
      if (op == OP_SAMPLE) begin
         res = MAGENTA;
         if (loaded && img_width != 0 && img_height != 0) begin
            x = nearest_pos(u, 32'(img_width));
            y = nearest_pos(v, 32'(img_height));
            t = texel_store[y * img_width + x];
            res.red = t[7:0];
            res.green = t[15:8];
            res.blue = t[23:16];
         end
         return 1'b1;
      end
      if (sof) begin
         pr_phase = PH_HEADER;
         hdr_count = '0;
         field_acc = '0;
         data_offset = '0;
         img_width = '0;
         img_height = '0;
         col = '0;
         row = '0;
         chan = '0;
         pad_cnt = '0;
         held_bg = '0;
         loaded = 1'b0;
         size_fault = 1'b0;
      end
      case (pr_phase)
         PH_HEADER: begin
            idx = hdr_count;
            field_acc = {data, field_acc[31:8]};
            hdr_count = idx + 1;
            if ((idx == IDX_SIG_FIRST && data != SIG_FIRST) ||
                (idx == IDX_SIG_SECOND && data != SIG_SECOND)) begin
               res = status_out(ST_BAD_SIG);
               return 1'b1;
            end
            if (idx == IDX_OFFSET_END) data_offset = field_acc;
            if (idx == IDX_WIDTH_END || idx == IDX_HEIGHT_END) begin
               bad = (field_acc == 0) || (field_acc > MAX_DIM);
               if (bad) size_fault = 1'b1;
               if (idx == IDX_WIDTH_END) img_width = bad ? '0 : field_acc[DIM_BITS-1:0];
               else img_height = bad ? '0 : field_acc[DIM_BITS-1:0];
            end
            if (idx == IDX_DEPTH_END) begin
               // Depth is judged first, then the sizes, then the offset.
               if (field_acc[31:16] != BIT_DEPTH) begin
                  res = status_out(ST_BAD_DEPTH);
                  return 1'b1;
               end
               if (size_fault) begin
                  res = status_out(ST_BAD_SIZE);
                  return 1'b1;
               end
               if (data_offset < MIN_OFFSET) begin
                  res = status_out(ST_BAD_OFFSET);
                  return 1'b1;
               end
               row = POS_BITS'(img_height - 1);
               col = '0;
               chan = '0;
               pr_phase = (data_offset == MIN_OFFSET) ? PH_PIXEL : PH_SKIP;
            end
         end
         PH_SKIP: begin
            hdr_count++;
            if (hdr_count == data_offset) pr_phase = PH_PIXEL;
         end
         PH_PIXEL: begin
            if (chan < 2) begin
               held_bg = {held_bg[7:0], data};
               chan++;
            end else begin
               chan = '0;
               addr = row * img_width + col;
               texel_store[addr] = {data, held_bg[7:0], held_bg[15:8]};
               if (col + 1 < img_width) begin
                  col++;
               end else if (row == 0) begin
                  // The last texel completes the load; its row padding is not awaited.
                  loaded = 1'b1;
                  res = status_out(ST_OK);
                  return 1'b1;
               end else if (img_width[1:0] != 0) begin
                  pad_cnt = img_width[1:0];
                  pr_phase = PH_PAD;
               end else begin
                  row--;
                  col = '0;
               end
            end
         end
         PH_PAD: begin
            if (pad_cnt > 0) pad_cnt--;
            if (pad_cnt == 0) begin
               row--;
               col = '0;
               pr_phase = PH_PIXEL;
            end
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   task automatic send_item(input logic op, input logic sof, input logic [7:0] data,
                            input logic [COORD_BITS-1:0] u, input logic [COORD_BITS-1:0] v);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {v, u, data};
      req_tuser <= {sof, op};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic issue(input logic op, input logic sof, input logic [7:0] data,
                        input logic [COORD_BITS-1:0] u, input logic [COORD_BITS-1:0] v);
      tex_result_t res;
      send_item(op, sof, data, u, v);
      if (op == OP_SAMPLE || sof || pr_phase != PH_IDLE) live_items++;
      if (bmp_step(op, sof, data, u, v, res)) due_outputs.push_back(res);
   endtask

   function automatic logic [COORD_BITS-1:0] rand_coord();
      logic [COORD_BITS-1:0] c;
      c = COORD_BITS'($urandom);
      case ($urandom_range(5))
         0: c[FRAC_BITS-1:0] = '0;
         1: c[FRAC_BITS-1:0] = '1;
         2: c[FRAC_BITS-1:0] = {1'b1, {(FRAC_BITS-1){1'b0}}};
         3: c[FRAC_BITS-1:0] = {1'b0, {(FRAC_BITS-1){1'b1}}};
         default: ;
      endcase
      return c;
   endfunction

   task automatic sample_burst(input int unsigned n);
      for (int i = 0; i < n; i++) begin
         issue(OP_SAMPLE, 1'($urandom_range(1)), 8'($urandom), rand_coord(), rand_coord());
      end
   endtask

   // Header of 30 bytes, gap up to the data offset and padded BGR rows when the header holds.
   function automatic void build_file(input logic [31:0] w_raw, input logic [31:0] h_raw,
                                      input logic [15:0] depth, input logic [31:0] offset);
      file_bytes.delete();
      for (int i = 0; i < 30; i++) file_bytes.push_back(8'($urandom));
      file_bytes[0] = SIG_FIRST;
      file_bytes[1] = SIG_SECOND;
      for (int i = 0; i < 4; i++) begin
         file_bytes[10 + i] = offset[8*i +: 8];
         file_bytes[18 + i] = w_raw[8*i +: 8];
         file_bytes[22 + i] = h_raw[8*i +: 8];
      end
      file_bytes[28] = depth[7:0];
      file_bytes[29] = depth[15:8];
      if (depth == BIT_DEPTH && w_raw != 0 && w_raw <= MAX_DIM && h_raw != 0 &&
          h_raw <= MAX_DIM && offset >= MIN_OFFSET) begin
         for (int i = 30; i < int'(offset); i++) file_bytes.push_back(8'($urandom));
         for (int r = 0; r < int'(h_raw); r++) begin
            for (int i = 0; i < 3 * int'(w_raw); i++) file_bytes.push_back(8'($urandom));
            for (int i = 0; i < int'(w_raw % 4); i++) file_bytes.push_back(8'($urandom));
         end
      end
   endfunction

   task automatic send_file(input int unsigned keep, input int unsigned sample_pct);
      for (int i = 0; i < file_bytes.size() && i < keep; i++) begin
         if ($urandom_range(99) < sample_pct) begin
            issue(OP_SAMPLE, 1'($urandom_range(1)), 8'($urandom), rand_coord(), rand_coord());
         end
         issue(OP_BYTE, i == 0, file_bytes[i], COORD_BITS'($urandom), COORD_BITS'($urandom));
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (due_outputs.size() != 0);
   endtask

   function automatic logic [31:0] bad_dim();
      case ($urandom_range(3))
         0: return 32'd0;
         1: return MAX_DIM + 1;
         2: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      tex_result_t oldest;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_outputs.size() == 0) begin
            $display("%0t: unexpected result, expected none, got kind %0b data %h",
                     $time, rsp_tuser, rsp_tdata);
            errors++;
         end else begin
            oldest = due_outputs.pop_front();
            check_field("result_kind", 8'(oldest.kind), 8'(rsp_tuser));
            check_field("red", oldest.red, rsp_tdata[7:0]);
            check_field("green", oldest.green, rsp_tdata[15:8]);
            check_field("blue", oldest.blue, rsp_tdata[23:16]);
            check_field("load_status", 8'(oldest.status), 8'(rsp_tdata[26:24]));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_bmp_texture_load_and_nearest_sample: done, errors");
         $finish;
      end
   end

   initial begin
      tex_result_t res;
      bit          got_any;
      int unsigned rand_start;
      int unsigned done_items;
      logic [31:0] w;
      logic [31:0] h;
      logic [31:0] offs;
      logic [15:0] depth;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         send_item(script[i].op, script[i].sof, script[i].data, script[i].u, script[i].v);
         got_any = bmp_step(script[i].op, script[i].sof, script[i].data, script[i].u,
                            script[i].v, res);
         if (script[i].typed) begin
            if (script[i].yields) due_outputs.push_back(script[i].want);
         end else if (got_any) begin
            due_outputs.push_back(res);
         end
      end

      // Whole files: good loads with and without padding or skipped bytes, then the depth, size and offset faults.
      build_file(4, 2, BIT_DEPTH, 30);
      send_file(file_bytes.size(), 0);
      sample_burst(8);
      build_file(3, 3, BIT_DEPTH, 34);
      send_file(file_bytes.size(), 10);
      sample_burst(8);
      build_file(0, 3, 16'd32, 30);
      send_file(file_bytes.size(), 0);
      build_file(0, 3, BIT_DEPTH, 30);
      send_file(file_bytes.size(), 0);
      build_file(MAX_DIM + 1, 3, BIT_DEPTH, 30);
      send_file(file_bytes.size(), 0);
      build_file(5, 32'hffff_fffe, BIT_DEPTH, 30);
      send_file(file_bytes.size(), 0);
      build_file(MAX_DIM, 0, BIT_DEPTH, 12);
      send_file(file_bytes.size(), 0);
      build_file(2, 2, BIT_DEPTH, 29);
      send_file(file_bytes.size(), 0);
      build_file(2, 2, BIT_DEPTH, 0);
      send_file(file_bytes.size(), 0);
      sample_burst(3);
      build_file(MAX_DIM, 1, BIT_DEPTH, 30);
      send_file(file_bytes.size(), 1);
      sample_burst(10);
      // The tallest height passes the size check, so the short offset is what fails.
      build_file(1, MAX_DIM, BIT_DEPTH, 29);
      send_file(file_bytes.size(), 0);
      sample_burst(10);
      // A load cut short leaves no valid texture behind.
      build_file(6, 4, BIT_DEPTH, 30);
      send_file(40, 0);
      sample_burst(2);
      drain();

      rand_start = live_items;
      while (live_items - rand_start < RANDOM_ITEMS) begin
         done_items = live_items - rand_start;
         if (done_items < RANDOM_ITEMS / 3) begin
            snd_idle_pct = 16;
            rcv_idle_pct = 59;
         end else if (done_items < 2 * RANDOM_ITEMS / 3) begin
            snd_idle_pct = 59;
            rcv_idle_pct = 16;
         end else begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
         end
         w = $urandom_range(1, 9);
         h = $urandom_range(1, 6);
         offs = ($urandom_range(1) != 0) ? 30 : $urandom_range(31, 38);
         depth = BIT_DEPTH;
         case ($urandom_range(19))
            13, 14: begin
               case ($urandom_range(3))
                  0: depth = 16'($urandom);
                  1: w = bad_dim();
                  2: h = bad_dim();
                  default: offs = $urandom_range(29);
               endcase
               build_file(w, h, depth, offs);
               send_file(file_bytes.size(), 3);
               sample_burst($urandom_range(1, 3));
            end
            15: begin
               build_file(w, h, depth, offs);
               send_file($urandom_range(1, file_bytes.size()), 5);
               sample_burst($urandom_range(1, 3));
            end
            16: begin
               for (int i = $urandom_range(1, 8); i > 0; i--) begin
                  issue(1'($urandom_range(1)), 1'($urandom_range(3) == 0), 8'($urandom),
                        COORD_BITS'($urandom), COORD_BITS'($urandom));
               end
            end
            17: sample_burst($urandom_range(1, 12));
            18: drain();
            default: begin
               build_file(w, h, depth, offs);
               send_file(file_bytes.size(), 5);
               sample_burst($urandom_range(2, 10));
            end
         endcase
      end

      req_tvalid <= 1'b0;
      while (due_outputs.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("tb_bmp_texture_load_and_nearest_sample: done, clean");
      end else begin
         $display("tb_bmp_texture_load_and_nearest_sample: done, errors");
      end
      $finish;
   end

endmodule

/* bmp_texture_load_and_nearest_sample.f */
rtl/core/btl_pkg.sv
rtl/core/btl_ram.sv
rtl/core/bmp_texture_load_and_nearest_sample.sv
sim/tb_bmp_texture_load_and_nearest_sample.sv
